// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the design. Compiled away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked while reset is released
`define ASSERT_CHK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: design/lvdt_pkg.sv
// ----------------------------------------------------------------------------
// lvdt_pkg
// Types and constants of the LVDS input delay edge training unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lvdt_pkg;

  // Lane and tap geometry
  localparam int NUM_LANES   = 14;
  localparam int TAP_COUNT   = 32;
  localparam int SAMPLE_BITS = 14;
  localparam int NUM_BITS    = 2 * NUM_LANES;

  // Field widths
  localparam int TAP_W  = 5;
  localparam int LANE_W = 4;
  localparam int BIT_W  = 5;
  localparam int KIND_W = 2;
  localparam int POS_W  = $clog2(SAMPLE_BITS);

  localparam logic [TAP_W-1:0]  TAP_MAX         = TAP_W'(TAP_COUNT - 1);
  localparam logic [TAP_W-1:0]  EDGE_OFFSET_RST = TAP_W'(8);
  localparam logic [LANE_W-1:0] LANE_LAST       = LANE_W'(NUM_LANES - 1);
  localparam logic [LANE_W-1:0] LANE_CH_B       = LANE_W'(NUM_LANES / 2);
  localparam logic [BIT_W-1:0]  BIT_WRAP        = BIT_W'(SAMPLE_BITS);

  // Request codes
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SET_TAP     = 2'd0,
    KIND_LANE_RESULT = 2'd1,
    KIND_DONE        = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [LANE_W-1:0] lane;
    logic [TAP_W-1:0]  tap;
    logic              failed;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: design/lvdt_ifs.sv
// ----------------------------------------------------------------------------
// lvdt_ifs
// Valid/ready channels of the training unit: request, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel
interface lvdt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [lvdt_pkg::SAMPLE_BITS-1:0] sample_a;
  logic [lvdt_pkg::SAMPLE_BITS-1:0] sample_b;

  modport source (output valid, req_type, sample_a, sample_b, input ready);
  modport sink   (input valid, req_type, sample_a, sample_b, output ready);
endinterface

// Result channel
interface lvdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [lvdt_pkg::KIND_W-1:0] kind;
  logic [lvdt_pkg::LANE_W-1:0] lane;
  logic [lvdt_pkg::TAP_W-1:0]  tap;
  logic                        failed;
  logic                        last;

  modport source (output valid, kind, lane, tap, failed, last, input ready);
  modport sink   (input valid, kind, lane, tap, failed, last, output ready);
endinterface

// Configuration write channel (edge offset)
interface lvdt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lvdt_pkg::TAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/lvds_input_delay_edge_training_unit.sv
// ----------------------------------------------------------------------------
// lvds_input_delay_edge_training_unit
// Sweeps the input delay tap of each LVDS lane bit, finds the data edge in
// a static pattern and reports a centered tap per lane.
// ----------------------------------------------------------------------------
//
//   channel   dir  width  carries
//   in_ch     in   29     req_type, sample_a, sample_b
//   out_ch    out  13     kind, lane, tap, failed, last
//   cfg_ch    in   5      edge_offset
//
// One request item is taken per cycle while in_ch.ready is high; it is evaluated
// combinationally from the sweep state and its one or two results enter a
// 4-entry result queue whose head drives out_ch. in_ch.ready is high while
// the queue has room for two results, so with the result side stalled
// requests are held off after two or three more items that produce results
// (samples taken while idle produce none). Reset is synchronous, active low,
// and sets edge_offset to 8. cfg_ch is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lvds_input_delay_edge_training_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lvdt_in_if.sink         in_ch,
  lvdt_out_if.source      out_ch,
  lvdt_cfg_if.sink        cfg_ch
);

  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;

  // Configuration and sweep state
  logic [lvdt_pkg::TAP_W-1:0]  edge_offset_r;
  logic                        busy_r, busy_nxt;
  logic [lvdt_pkg::BIT_W-1:0]  bit_index_r, bit_index_nxt;
  logic [lvdt_pkg::TAP_W-1:0]  sweep_tap_r, sweep_tap_nxt;
  logic                        prev_val_r, prev_val_nxt;
  logic [lvdt_pkg::TAP_W-1:0]  even_delay_r, even_delay_nxt;
  logic                        even_ok_r, even_ok_nxt;
  logic                        any_error_r, any_error_nxt;

  // Result queue
  lvdt_pkg::res_t              q_r [QDEPTH];
  lvdt_pkg::res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0]           q_cnt_r, q_cnt_nxt;

  logic                        in_acc;
  logic                        start_acc;
  logic                        pop;
  logic [1:0]                  push_n;
  lvdt_pkg::res_t              res0, res1;

  // Per-sample evaluation signals
  logic [lvdt_pkg::LANE_W-1:0] lane;
  logic [lvdt_pkg::SAMPLE_BITS-1:0] word;
  logic [lvdt_pkg::BIT_W-1:0]  pos_full;
  logic [lvdt_pkg::POS_W-1:0]  pos;
  logic                        val;
  logic [lvdt_pkg::TAP_W:0]    tap_up;
  logic [lvdt_pkg::TAP_W-1:0]  tap_sel;
  logic [lvdt_pkg::TAP_W:0]    avg_sum;
  logic                        rise, fall, timeout, done, ok;
  logic                        lane_bad;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign start_acc    = in_acc && (in_ch.req_type == lvdt_pkg::REQ_START);
  assign pop          = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign cfg_ch.ready = 1'b1;

  // Sample bit under test
  always_comb begin
    lane     = bit_index_r[lvdt_pkg::BIT_W-1:1];
    word     = (lane >= lvdt_pkg::LANE_CH_B) ? in_ch.sample_b : in_ch.sample_a;
    pos_full = (bit_index_r >= lvdt_pkg::BIT_WRAP) ? bit_index_r - lvdt_pkg::BIT_WRAP
                                                   : bit_index_r;
    pos      = pos_full[lvdt_pkg::POS_W-1:0];
    val      = word[pos] ^ bit_index_r[0];
  end

  // Edge detection and tap choice
  always_comb begin
    rise    = (sweep_tap_r != '0) && !prev_val_r && val;
    fall    = (sweep_tap_r != '0) && prev_val_r && !val;
    timeout = (sweep_tap_r == lvdt_pkg::TAP_MAX);
    done    = rise || fall || timeout;
    ok      = rise || fall;
    tap_up  = {1'b0, sweep_tap_r} + {1'b0, edge_offset_r};
    if (rise) begin
      tap_sel = (tap_up > {1'b0, lvdt_pkg::TAP_MAX}) ? lvdt_pkg::TAP_MAX
                                                     : tap_up[lvdt_pkg::TAP_W-1:0];
    end else if (fall) begin
      tap_sel = (sweep_tap_r >= edge_offset_r) ? sweep_tap_r - edge_offset_r : '0;
    end else begin
      tap_sel = '0;
    end
    avg_sum  = {1'b0, even_delay_r} + {1'b0, tap_sel};
    lane_bad = !(ok && even_ok_r);
  end

  // Next sweep state and results of the accepted item
  always_comb begin
    busy_nxt       = busy_r;
    bit_index_nxt  = bit_index_r;
    sweep_tap_nxt  = sweep_tap_r;
    prev_val_nxt   = prev_val_r;
    even_delay_nxt = even_delay_r;
    even_ok_nxt    = even_ok_r;
    any_error_nxt  = any_error_r;
    push_n         = 2'd0;
    res0           = '{kind: lvdt_pkg::KIND_SET_TAP, lane: '0, tap: '0,
                       failed: 1'b0, last: 1'b1};
    res1           = res0;
    if (in_acc) begin
      if (in_ch.req_type == lvdt_pkg::REQ_START) begin
        busy_nxt       = 1'b1;
        any_error_nxt  = 1'b0;
        even_ok_nxt    = 1'b0;
        even_delay_nxt = '0;
        bit_index_nxt  = '0;
        sweep_tap_nxt  = '0;
        prev_val_nxt   = 1'b0;
        push_n         = 2'd1;
      end else if (busy_r) begin
        res0.lane = lane;
        if (!done) begin
          // keep sweeping
          sweep_tap_nxt = sweep_tap_r + 1'b1;
          prev_val_nxt  = val;
          res0.tap      = sweep_tap_r + 1'b1;
          push_n        = 2'd1;
        end else if (!bit_index_r[0]) begin
          // even bit ended, start odd bit of the same lane
          even_delay_nxt = tap_sel;
          even_ok_nxt    = ok;
          bit_index_nxt  = bit_index_r + 1'b1;
          sweep_tap_nxt  = '0;
          prev_val_nxt   = 1'b0;
          push_n         = 2'd1;
        end else begin
          // odd bit ended: lane result, then next lane or finish
          res0.kind   = lvdt_pkg::KIND_LANE_RESULT;
          res0.last   = 1'b0;
          res0.failed = lane_bad;
          res0.tap    = lane_bad ? '0 : avg_sum[lvdt_pkg::TAP_W:1];
          if (lane_bad) begin
            any_error_nxt = 1'b1;
          end
          sweep_tap_nxt = '0;
          prev_val_nxt  = 1'b0;
          push_n        = 2'd2;
          if (lane == lvdt_pkg::LANE_LAST) begin
            busy_nxt      = 1'b0;
            bit_index_nxt = '0;
            res1.kind     = lvdt_pkg::KIND_DONE;
            res1.failed   = any_error_r || lane_bad;
          end else begin
            bit_index_nxt = bit_index_r + 1'b1;
            res1.lane     = lane + 1'b1;
          end
        end
      end
    end
  end

  // Result queue: slot 0 is the head, entries move down on a pop
  always_comb begin
    logic [QCNT_W-1:0] cnt_pop;
    cnt_pop = q_cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if ((push_n != 2'd0) && (QCNT_W'(i) == cnt_pop)) begin
        q_nxt[i] = res0;
      end
      if ((push_n == 2'd2) && (QCNT_W'(i) == cnt_pop + 1'b1)) begin
        q_nxt[i] = res1;
      end
    end
    q_cnt_nxt = cnt_pop + QCNT_W'(push_n);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_offset_r <= lvdt_pkg::EDGE_OFFSET_RST;
      busy_r        <= 1'b0;
      bit_index_r   <= '0;
      sweep_tap_r   <= '0;
      prev_val_r    <= 1'b0;
      even_delay_r  <= '0;
      even_ok_r     <= 1'b0;
      any_error_r   <= 1'b0;
      q_cnt_r       <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        edge_offset_r <= cfg_ch.data;
      end
      busy_r       <= busy_nxt;
      bit_index_r  <= bit_index_nxt;
      sweep_tap_r  <= sweep_tap_nxt;
      prev_val_r   <= prev_val_nxt;
      even_delay_r <= even_delay_nxt;
      even_ok_r    <= even_ok_nxt;
      any_error_r  <= any_error_nxt;
      q_cnt_r      <= q_cnt_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Output drive from the queue head
  assign out_ch.valid  = (q_cnt_r != '0);
  assign out_ch.kind   = q_r[0].kind;
  assign out_ch.lane   = q_r[0].lane;
  assign out_ch.tap    = q_r[0].tap;
  assign out_ch.failed = q_r[0].failed;
  assign out_ch.last   = q_r[0].last;

  // Checks
  `ASSERT_CHK(a_q_bound, clk, rst_n, q_cnt_r <= QCNT_W'(QDEPTH))
  `ASSERT_CHK(a_start_busy, clk, rst_n, start_acc |=> busy_r && (q_cnt_r != '0))
  `ASSERT_CHK(a_bit_range, clk, rst_n, busy_r |-> bit_index_r < lvdt_pkg::BIT_W'(28))
  `ASSERT_CHK(a_idle_clean, clk, rst_n, !busy_r |-> (bit_index_r == '0) && (sweep_tap_r == '0))
  `ASSERT_CHK(a_done_last, clk, rst_n, pop && (out_ch.kind == lvdt_pkg::KIND_DONE) |-> out_ch.last)

endmodule

`default_nettype wire
